FILE: sv/assert_macros.svh
// Assertion macros used by the checker of the GPIO register block.
// No dependencies; take it in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define GPC_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define GPC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/gpc_pkg.sv
// Shared types, register offsets and constants of the GPIO register block.
// No dependencies; imported by every module of the block.
`default_nettype none

package gpc_pkg;

  localparam int NUM_PINS_DEF  = 54;
  localparam int WORD_W        = 32;
  localparam int OFF_W         = 6;
  localparam int PAD_LO_W      = 32;
  localparam int PAD_HI_W      = 22;
  localparam int HI_BASE       = 32;
  localparam int PIN_VEC_W     = 64;
  localparam int FSEL_WORDS    = 6;
  localparam int FSEL_IDX_W    = 3;
  localparam int FSEL_PER_WORD = 10;
  localparam int FUNC_W        = 3;
  localparam int FSEL_W        = FSEL_PER_WORD * FUNC_W;
  localparam int PULL_W        = 2;
  localparam int PULL_LO_W     = 64;
  localparam int PULL_HI_W     = 44;
  localparam int PULL_VEC_W    = PIN_VEC_W * PULL_W;

  localparam logic [FUNC_W-1:0] FUNC_OUTPUT = 3'd1;
  localparam logic              CMD_WRITE   = 1'b1;

  // Word offsets (byte offset / 4)
  localparam logic [OFF_W-1:0] OFF_FSEL0   = 6'd0;
  localparam logic [OFF_W-1:0] OFF_FSEL5   = 6'd5;
  localparam logic [OFF_W-1:0] OFF_SET0    = 6'd7;
  localparam logic [OFF_W-1:0] OFF_SET1    = 6'd8;
  localparam logic [OFF_W-1:0] OFF_CLR0    = 6'd10;
  localparam logic [OFF_W-1:0] OFF_CLR1    = 6'd11;
  localparam logic [OFF_W-1:0] OFF_LEV0    = 6'd13;
  localparam logic [OFF_W-1:0] OFF_LEV1    = 6'd14;
  localparam logic [OFF_W-1:0] OFF_PUD     = 6'd37;
  localparam logic [OFF_W-1:0] OFF_PUDCLK0 = 6'd38;
  localparam logic [OFF_W-1:0] OFF_PUDCLK1 = 6'd39;

  typedef struct packed {
    logic                valid;
    logic                command;
    logic [OFF_W-1:0]    reg_offset;
    logic [WORD_W-1:0]   write_data;
    logic [PAD_HI_W-1:0] pad_high;
    logic [PAD_LO_W-1:0] pad_low;
  } gpc_req_t;

  // Writable bits of all function-select words, word w at bits w*FSEL_W
  function automatic logic [FSEL_WORDS*FSEL_W-1:0] fsel_masks(int num_pins);
    logic [FSEL_WORDS*FSEL_W-1:0] m;
    m = '0;
    for (int w = 0; w < FSEL_WORDS; w++) begin
      for (int k = 0; k < FSEL_PER_WORD; k++) begin
        if (w * FSEL_PER_WORD + k < num_pins) begin
          m[w*FSEL_W + k*FUNC_W +: FUNC_W] = '1;
        end
      end
    end
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: sv/gpio_pin_controller.sv
// Channel   Ports                          Transfer
// input     start/busy, in_*               edge with start high and busy low
// result    out_valid, out_*               edge that ends the out_valid cycle
// Top level of the GPIO register block; depends on gpc_pkg, gpc_in_reg, gpc_regfile.
// One access per cycle while busy is low; out_valid is registered from the valid bit
// of the input register; the result transfers when the out_valid cycle ends.
// Latency is set by the input register and the result/state register stage.
// Reset clears function select, latch, pull code and pin pulls;
// busy is high for the first cycle after reset. The receiver cannot stall.
`default_nettype none

module gpio_pin_controller #(
  parameter int NUM_PINS = gpc_pkg::NUM_PINS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_command,
  input  wire logic [gpc_pkg::OFF_W-1:0]     in_reg_offset,
  input  wire logic [gpc_pkg::WORD_W-1:0]    in_write_data,
  input  wire logic [gpc_pkg::PAD_LO_W-1:0]  in_pad_level_low,
  input  wire logic [gpc_pkg::PAD_HI_W-1:0]  in_pad_level_high,
  output logic                               out_valid,
  output logic [gpc_pkg::WORD_W-1:0]         out_read_data,
  output logic                               out_bad_offset,
  output logic [gpc_pkg::PAD_LO_W-1:0]       out_drive_low,
  output logic [gpc_pkg::PAD_HI_W-1:0]       out_drive_high,
  output logic [gpc_pkg::PAD_LO_W-1:0]       out_out_enable_low,
  output logic [gpc_pkg::PAD_HI_W-1:0]       out_out_enable_high,
  output logic [gpc_pkg::PULL_LO_W-1:0]      out_pull_low,
  output logic [gpc_pkg::PULL_HI_W-1:0]      out_pull_high
);
  import gpc_pkg::*;

  gpc_req_t req;

  gpc_in_reg u_in_reg (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_reg_offset     (in_reg_offset),
    .in_write_data     (in_write_data),
    .in_pad_level_low  (in_pad_level_low),
    .in_pad_level_high (in_pad_level_high),
    .req               (req)
  );

  gpc_regfile #(
    .NUM_PINS (NUM_PINS)
  ) u_regfile (
    .clk                 (clk),
    .rst_n               (rst_n),
    .req                 (req),
    .out_valid           (out_valid),
    .out_read_data       (out_read_data),
    .out_bad_offset      (out_bad_offset),
    .out_drive_low       (out_drive_low),
    .out_drive_high      (out_drive_high),
    .out_out_enable_low  (out_out_enable_low),
    .out_out_enable_high (out_out_enable_high),
    .out_pull_low        (out_pull_low),
    .out_pull_high       (out_pull_high)
  );

endmodule

`default_nettype wire

FILE: sv/gpc_in_reg.sv
// Input register of the GPIO register block: captures one bus access per cycle
// while busy is low. Depends on gpc_pkg.
`default_nettype none

module gpc_in_reg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_command,
  input  wire logic [gpc_pkg::OFF_W-1:0]     in_reg_offset,
  input  wire logic [gpc_pkg::WORD_W-1:0]    in_write_data,
  input  wire logic [gpc_pkg::PAD_LO_W-1:0]  in_pad_level_low,
  input  wire logic [gpc_pkg::PAD_HI_W-1:0]  in_pad_level_high,
  output gpc_pkg::gpc_req_t                  req
);
  import gpc_pkg::*;

  logic     busy_r;
  logic     valid_r;
  gpc_req_t req_r;

  // hold off transfers for the cycle right after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b1;
      valid_r <= 1'b0;
    end else begin
      busy_r  <= 1'b0;
      valid_r <= start && !busy_r;
    end
  end

  always_ff @(posedge clk) begin
    req_r.valid      <= 1'b0;
    req_r.command    <= in_command;
    req_r.reg_offset <= in_reg_offset;
    req_r.write_data <= in_write_data;
    req_r.pad_high   <= in_pad_level_high;
    req_r.pad_low    <= in_pad_level_low;
  end

  always_comb begin
    req       = req_r;
    req.valid = valid_r;
  end

  assign busy = busy_r;

endmodule

`default_nettype wire

FILE: sv/gpc_regfile.sv
// Register file of the GPIO register block: decode, state update, result register.
// Depends on gpc_pkg; fed by gpc_in_reg.
`default_nettype none

module gpc_regfile #(
  parameter int NUM_PINS = gpc_pkg::NUM_PINS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire gpc_pkg::gpc_req_t             req,
  output logic                               out_valid,
  output logic [gpc_pkg::WORD_W-1:0]         out_read_data,
  output logic                               out_bad_offset,
  output logic [gpc_pkg::PAD_LO_W-1:0]       out_drive_low,
  output logic [gpc_pkg::PAD_HI_W-1:0]       out_drive_high,
  output logic [gpc_pkg::PAD_LO_W-1:0]       out_out_enable_low,
  output logic [gpc_pkg::PAD_HI_W-1:0]       out_out_enable_high,
  output logic [gpc_pkg::PULL_LO_W-1:0]      out_pull_low,
  output logic [gpc_pkg::PULL_HI_W-1:0]      out_pull_high
);
  import gpc_pkg::*;

  localparam logic [FSEL_WORDS*FSEL_W-1:0] FSEL_MASKS = fsel_masks(NUM_PINS);

  logic [FSEL_W-1:0]    fsel_r   [FSEL_WORDS];
  logic [FSEL_W-1:0]    fsel_nxt [FSEL_WORDS];
  logic [NUM_PINS-1:0]  latch_r, latch_nxt;
  logic [PULL_W-1:0]    pud_r, pud_nxt;
  logic [PULL_W-1:0]    pin_pull_r [NUM_PINS];
  logic [NUM_PINS-1:0]  pull_hit;
  logic [NUM_PINS-1:0]  oe, wbits, pads, lev;
  logic [PIN_VEC_W-1:0] wdata_sh, pads_ext, latch_ext, oe_ext, lev_ext;
  logic [PULL_VEC_W-1:0] pull_vec;
  logic [FSEL_IDX_W-1:0] fsel_idx;
  logic                  upper_word, wr;
  logic [WORD_W-1:0]     rd, read_data_r, read_data_nxt;
  logic                  bad, bad_offset_r, out_valid_r;

  assign wr         = (req.command == CMD_WRITE);
  assign fsel_idx   = req.reg_offset[FSEL_IDX_W-1:0];
  assign upper_word = (req.reg_offset == OFF_SET1) || (req.reg_offset == OFF_CLR1) ||
                      (req.reg_offset == OFF_PUDCLK1);

  assign wdata_sh = upper_word ? {req.write_data, {HI_BASE{1'b0}}}
                               : PIN_VEC_W'(req.write_data);
  assign wbits    = wdata_sh[NUM_PINS-1:0];
  assign pads_ext = PIN_VEC_W'({req.pad_high, req.pad_low});
  assign pads     = pads_ext[NUM_PINS-1:0];

  for (genvar n = 0; n < NUM_PINS; n++) begin : g_oe
    assign oe[n] = (fsel_r[n / FSEL_PER_WORD][FUNC_W*(n % FSEL_PER_WORD) +: FUNC_W]
                    == FUNC_OUTPUT);
  end

  assign lev     = (latch_r & oe) | (pads & ~oe);
  assign lev_ext = PIN_VEC_W'(lev);

  always_comb begin
    fsel_nxt  = fsel_r;
    latch_nxt = latch_r;
    pud_nxt   = pud_r;
    pull_hit  = '0;
    rd        = '0;
    bad       = 1'b0;
    if (req.valid) begin
      unique case (req.reg_offset) inside
        [OFF_FSEL0:OFF_FSEL5]: begin
          if (wr) begin
            fsel_nxt[fsel_idx] = req.write_data[FSEL_W-1:0] &
                                 FSEL_MASKS[fsel_idx*FSEL_W +: FSEL_W];
          end else begin
            rd = WORD_W'(fsel_r[fsel_idx]);
          end
        end
        OFF_SET0, OFF_SET1: begin
          if (wr) latch_nxt = latch_r | wbits;
        end
        OFF_CLR0, OFF_CLR1: begin
          if (wr) latch_nxt = latch_r & ~wbits;
        end
        OFF_LEV0, OFF_LEV1: begin
          if (!wr) begin
            rd = (req.reg_offset == OFF_LEV1) ? lev_ext[HI_BASE +: WORD_W]
                                              : lev_ext[WORD_W-1:0];
          end
        end
        OFF_PUD: begin
          if (wr) pud_nxt = req.write_data[PULL_W-1:0];
          else    rd      = WORD_W'(pud_r);
        end
        OFF_PUDCLK0, OFF_PUDCLK1: begin
          if (wr) pull_hit = wbits;
        end
        default: bad = 1'b1;
      endcase
    end
  end

  assign read_data_nxt = wr ? '0 : rd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < FSEL_WORDS; w++) fsel_r[w] <= '0;
      for (int n = 0; n < NUM_PINS; n++) pin_pull_r[n] <= '0;
      latch_r     <= '0;
      pud_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fsel_r      <= fsel_nxt;
      latch_r     <= latch_nxt;
      pud_r       <= pud_nxt;
      out_valid_r <= req.valid;
      // pull clock copies the held code into each selected pin
      for (int n = 0; n < NUM_PINS; n++) begin
        if (pull_hit[n]) pin_pull_r[n] <= pud_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    read_data_r  <= read_data_nxt;
    bad_offset_r <= bad;
  end

  for (genvar n = 0; n < PIN_VEC_W; n++) begin : g_pull
    if (n < NUM_PINS) begin : g_pin
      assign pull_vec[PULL_W*n +: PULL_W] = pin_pull_r[n];
    end else begin : g_none
      assign pull_vec[PULL_W*n +: PULL_W] = '0;
    end
  end

  assign latch_ext = PIN_VEC_W'(latch_r);
  assign oe_ext    = PIN_VEC_W'(oe);

  assign out_valid           = out_valid_r;
  assign out_read_data       = read_data_r;
  assign out_bad_offset      = bad_offset_r;
  assign out_drive_low       = latch_ext[PAD_LO_W-1:0];
  assign out_drive_high      = latch_ext[HI_BASE +: PAD_HI_W];
  assign out_out_enable_low  = oe_ext[PAD_LO_W-1:0];
  assign out_out_enable_high = oe_ext[HI_BASE +: PAD_HI_W];
  assign out_pull_low        = pull_vec[PULL_LO_W-1:0];
  assign out_pull_high       = pull_vec[PULL_LO_W +: PULL_HI_W];

endmodule

`default_nettype wire

FILE: sv/gpc_checker.sv
// Port-level checker of the GPIO register block, bound to gpio_pin_controller.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module gpc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        in_command,
  input wire logic        out_valid,
  input wire logic [31:0] out_read_data,
  input wire logic        out_bad_offset
);

  `GPC_ASSERT_NEXT(a_result_follows, clk, rst_n, start && !busy, ##1 out_valid, "transfer without result")
  `GPC_ASSERT_NOW(a_no_phantom, clk, rst_n, out_valid, $past(start && !busy, 2), "result without transfer")
  `GPC_ASSERT_NOW(a_bad_reads_zero, clk, rst_n, out_valid && out_bad_offset, out_read_data == 32'd0, "bad offset returned data")
  `GPC_ASSERT_NOW(a_write_reads_zero, clk, rst_n, out_valid && $past(in_command, 2), out_read_data == 32'd0, "write returned data")

endmodule

bind gpio_pin_controller gpc_checker u_gpc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_command     (in_command),
  .out_valid      (out_valid),
  .out_read_data  (out_read_data),
  .out_bad_offset (out_bad_offset)
);

`default_nettype wire
